// ===== rtl/dsdq_pkg.sv =====
// Shared types and constants for the depth sorted draw queue.
// Word formats, camera registers, queued operations and control codes.
// No dependencies.
package dsdq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int FIFO_DEPTH_DEF  = 4;

   localparam int POS_W   = 32;
   localparam int DIR_W   = 16;
   localparam int DIFF_W  = 33;
   localparam int PROD_W  = 49;
   localparam int KEY_W   = 51;
   localparam int HANDLE_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CAM_POS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_POS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_POS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_DIR_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_DIR_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_DIR_Z = 3'd5;

   localparam logic signed [DIR_W-1:0] CAM_DIR_Z_RESET = 16'sd16384;

   localparam logic [1:0] STATUS_IMMEDIATE = 2'd0;
   localparam logic [1:0] STATUS_SORTED    = 2'd1;
   localparam logic [1:0] STATUS_DROPPED   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef struct packed {
      logic                    cmd;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [HANDLE_W-1:0]     item_handle;
      logic                    has_alpha;
      logic                    use_camera_pos;
      logic                    visible;
      logic                    offscreen;
      logic                    resources_present;
   } req_word_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] draw_handle;
      logic [1:0]          status;
      logic                last;
   } rsp_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
   } cam_type;

   typedef enum logic [1:0] {
      OP_OPAQUE,
      OP_INSERT,
      OP_DRAIN
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [HANDLE_W-1:0]     handle;
      logic signed [KEY_W-1:0] key;
   } op_type;

   typedef enum logic {
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/depth_sorted_draw_queue.sv =====
// Depth sorted draw queue, top level: camera registers, front end, queue, sort engine.
// A submit passes the front-end stages and the operation queue before the result register.
// Throughput: one submit per cycle when nothing downstream stalls; a drain dispatches first,
// then emits one entry a cycle out of the head of the shift chain while the output is free.
// Reset clears pipeline, queue and entry count at once; camera registers return to
// position zero and direction (0, 0, 1.0).
module depth_sorted_draw_queue #(
   parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH_DEF,
   parameter int FIFO_DEPTH  = dsdq_pkg::FIFO_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dsdq_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dsdq_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dsdq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dsdq_pkg::POS_W-1:0]       csr_data
);

   dsdq_pkg::cam_type cam_ff, cam_in;
   logic              push, push_ready, pop, pop_valid;
   dsdq_pkg::op_type  push_op, pop_op;

   assign csr_ready = 1'b1;

   always_comb begin
      cam_in = cam_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dsdq_pkg::CSR_CAM_POS_X: cam_in.pos_x = csr_data;
            dsdq_pkg::CSR_CAM_POS_Y: cam_in.pos_y = csr_data;
            dsdq_pkg::CSR_CAM_POS_Z: cam_in.pos_z = csr_data;
            dsdq_pkg::CSR_CAM_DIR_X: cam_in.dir_x = csr_data[dsdq_pkg::DIR_W-1:0];
            dsdq_pkg::CSR_CAM_DIR_Y: cam_in.dir_y = csr_data[dsdq_pkg::DIR_W-1:0];
            dsdq_pkg::CSR_CAM_DIR_Z: cam_in.dir_z = csr_data[dsdq_pkg::DIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff <= '{pos_x: '0, pos_y: '0, pos_z: '0, dir_x: '0, dir_y: '0,
                     dir_z: dsdq_pkg::CAM_DIR_Z_RESET};
      end else begin
         cam_ff <= cam_in;
      end
   end

   dsdq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .cam        (cam_ff),
      .push       (push),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   dsdq_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op)
   );

   dsdq_sort #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (pop_valid),
      .op        (pop_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/dsdq_front.sv =====
// Front end: accepts request words, filters and classifies them, computes depth keys.
// Three register stages; pushes operations into the queue. Uses dsdq_pkg.
module dsdq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dsdq_pkg::req_word_type req_word,
   input  dsdq_pkg::cam_type     cam,
   output logic                  push,
   output dsdq_pkg::op_type      push_op,
   input  logic                  push_ready
);

   logic                                  advance;
   logic                                  take;
   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s2_valid_ff;
   logic                                  s3_valid_ff;
   dsdq_pkg::op_kind_type                 s1_kind_ff, s1_kind_in;
   dsdq_pkg::op_kind_type                 s2_kind_ff, s3_kind_ff;
   logic [dsdq_pkg::HANDLE_W-1:0]         s1_handle_ff, s2_handle_ff, s3_handle_ff;
   logic signed [dsdq_pkg::DIFF_W-1:0]    dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [dsdq_pkg::PROD_W-1:0]    px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [dsdq_pkg::KEY_W-1:0]     key_ff, key_in;

   assign advance   = !s3_valid_ff || push_ready;
   assign req_ready = advance;
   assign take      = req_valid && advance;

   always_comb begin
      s1_valid_in = 1'b0;
      s1_kind_in  = dsdq_pkg::OP_OPAQUE;
      if (take) begin
         if (req_word.cmd == dsdq_pkg::CMD_DRAIN) begin
            s1_valid_in = 1'b1;
            s1_kind_in  = dsdq_pkg::OP_DRAIN;
         end else if (req_word.visible && !req_word.offscreen &&
                      req_word.resources_present) begin
            s1_valid_in = 1'b1;
            s1_kind_in  = req_word.has_alpha ? dsdq_pkg::OP_INSERT : dsdq_pkg::OP_OPAQUE;
         end
      end
   end

   always_comb begin
      if (req_word.use_camera_pos) begin
         dx_in = '0;
         dy_in = dsdq_pkg::DIFF_W'(cam.pos_y);
         dz_in = '0;
      end else begin
         dx_in = dsdq_pkg::DIFF_W'(cam.pos_x) - dsdq_pkg::DIFF_W'(req_word.pos_x);
         dy_in = dsdq_pkg::DIFF_W'(cam.pos_y) - dsdq_pkg::DIFF_W'(req_word.pos_y);
         dz_in = dsdq_pkg::DIFF_W'(cam.pos_z) - dsdq_pkg::DIFF_W'(req_word.pos_z);
      end
   end

   assign px_in  = dsdq_pkg::PROD_W'(dx_ff) * dsdq_pkg::PROD_W'(cam.dir_x);
   assign py_in  = dsdq_pkg::PROD_W'(dy_ff) * dsdq_pkg::PROD_W'(cam.dir_y);
   assign pz_in  = dsdq_pkg::PROD_W'(dz_ff) * dsdq_pkg::PROD_W'(cam.dir_z);
   assign key_in = dsdq_pkg::KEY_W'(px_ff) + dsdq_pkg::KEY_W'(py_ff) +
                   dsdq_pkg::KEY_W'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff   <= s1_kind_in;
         s1_handle_ff <= req_word.item_handle;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         dz_ff        <= dz_in;
         s2_kind_ff   <= s1_kind_ff;
         s2_handle_ff <= s1_handle_ff;
         px_ff        <= px_in;
         py_ff        <= py_in;
         pz_ff        <= pz_in;
         s3_kind_ff   <= s2_kind_ff;
         s3_handle_ff <= s2_handle_ff;
         key_ff       <= key_in;
      end
   end

   assign push           = s3_valid_ff && push_ready;
   assign push_op.kind   = s3_kind_ff;
   assign push_op.handle = s3_handle_ff;
   assign push_op.key    = key_ff;

endmodule

// ===== rtl/dsdq_fifo.sv =====
// Short operation queue between the front end and the sort engine.
// Register array with read and write pointers. Uses dsdq_pkg.
module dsdq_fifo #(
   parameter int FIFO_DEPTH = dsdq_pkg::FIFO_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dsdq_pkg::op_type push_op,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output dsdq_pkg::op_type pop_op
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   dsdq_pkg::op_type   mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign push_ready = cnt_ff != CNT_W'(FIFO_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_op     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/dsdq_sort.sv =====
// Sort engine: sorted shift chain of keys and handles, drain sequencer, result register.
// Takes operations from the queue. Uses dsdq_pkg.
module dsdq_sort #(
   parameter int QUEUE_DEPTH = dsdq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  dsdq_pkg::op_type       op,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dsdq_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic signed [dsdq_pkg::KEY_W-1:0] key_ff    [QUEUE_DEPTH];
   logic [dsdq_pkg::HANDLE_W-1:0]     handle_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]            gt;
   logic [CNT_W-1:0]                  count_ff, count_in;
   dsdq_pkg::state_type               state_ff, state_in;
   logic                              out_free;
   logic                              full;
   logic                              ins;
   logic                              shift;
   logic                              emit;
   dsdq_pkg::rsp_word_type            emit_word;
   logic                              rsp_valid_ff, rsp_valid_in;
   dsdq_pkg::rsp_word_type            rsp_word_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (key_ff[i] > op.key);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsdq_pkg::ST_RUN: begin
            if (op_valid && op.kind == dsdq_pkg::OP_DRAIN && count_ff != '0) begin
               state_in = dsdq_pkg::ST_DRAIN;
            end
         end
         dsdq_pkg::ST_DRAIN: begin
            if (out_free && count_ff == CNT_W'(1)) begin
               state_in = dsdq_pkg::ST_RUN;
            end
         end
         default: state_in = dsdq_pkg::ST_RUN;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      ins       = 1'b0;
      shift     = 1'b0;
      emit      = 1'b0;
      emit_word = '0;
      count_in  = count_ff;
      unique case (state_ff)
         dsdq_pkg::ST_RUN: begin
            if (op_valid) begin
               unique case (op.kind)
                  dsdq_pkg::OP_OPAQUE: begin
                     if (out_free) begin
                        pop                   = 1'b1;
                        emit                  = 1'b1;
                        emit_word.draw_handle = op.handle;
                        emit_word.status      = dsdq_pkg::STATUS_IMMEDIATE;
                        emit_word.last        = 1'b1;
                     end
                  end
                  dsdq_pkg::OP_INSERT: begin
                     if (!full) begin
                        pop      = 1'b1;
                        ins      = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else if (out_free) begin
                        pop                   = 1'b1;
                        emit                  = 1'b1;
                        emit_word.draw_handle = op.handle;
                        emit_word.status      = dsdq_pkg::STATUS_DROPPED;
                        emit_word.last        = 1'b1;
                     end
                  end
                  dsdq_pkg::OP_DRAIN: begin
                     if (count_ff != '0) begin
                        pop = 1'b1;
                     end else if (out_free) begin
                        pop              = 1'b1;
                        emit             = 1'b1;
                        emit_word.status = dsdq_pkg::STATUS_EMPTY;
                        emit_word.last   = 1'b1;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         dsdq_pkg::ST_DRAIN: begin
            if (out_free) begin
               shift                 = 1'b1;
               emit                  = 1'b1;
               emit_word.draw_handle = handle_ff[0];
               emit_word.status      = dsdq_pkg::STATUS_SORTED;
               emit_word.last        = count_ff == CNT_W'(1);
               count_in              = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsdq_pkg::ST_RUN;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= emit_word;
      end
   end

   // equal keys: new entry lands ahead of them
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      always_ff @(posedge clock) begin
         if (ins && !gt[g]) begin
            if (g == 0) begin
               key_ff[g]    <= op.key;
               handle_ff[g] <= op.handle;
            end else if (gt[(g == 0) ? 0 : g - 1]) begin
               key_ff[g]    <= op.key;
               handle_ff[g] <= op.handle;
            end else begin
               key_ff[g]    <= key_ff[(g == 0) ? 0 : g - 1];
               handle_ff[g] <= handle_ff[(g == 0) ? 0 : g - 1];
            end
         end else if (shift && g < QUEUE_DEPTH - 1) begin
            key_ff[g]    <= key_ff[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            handle_ff[g] <= handle_ff[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == dsdq_pkg::ST_DRAIN |-> count_ff != '0)
      else $error("drain state with empty list");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      ins |-> !full && !shift && !emit)
      else $error("insert collides with full list or output");

endmodule
